/* rtl/core/triangle_normal_and_area_defines.svh */
// assertion macros used by the checker file
`ifndef TRIANGLE_NORMAL_AND_AREA_DEFINES_SVH
`define TRIANGLE_NORMAL_AND_AREA_DEFINES_SVH

// checked only outside reset
`define TNA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TNA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tna_pkg.sv */
// ----------------------------------------------------------------------------
// tna_pkg
// widths, limits and stage types of the triangle normal and area pipeline
// ----------------------------------------------------------------------------
package tna_pkg;

	localparam int COORD_W = 16;
	localparam int EDGE_W  = 17;
	localparam int PROD_W  = 34;
	localparam int CROSS_W = 35;
	localparam int MAG_W   = 33;
	localparam int SQ_W    = 66;
	localparam int SUM_W   = 68;
	localparam int ROOT_W  = 34;
	localparam int REM_W   = 37;
	localparam int QUO_W   = 15;
	localparam int DREM_W  = 36;
	localparam int DSUM_W  = 49;
	localparam int NORM_W  = 16;
	localparam int AREA_W  = 21;
	localparam int AREA_RW = 22;

	localparam logic [QUO_W-1:0]  NORMAL_ONE = 15'd16384;
	localparam logic [AREA_W-1:0] AREA_MAX   = '1;

	typedef struct packed {
		logic [2:0]       neg;
		logic [MAG_W-1:0] mx;
		logic [MAG_W-1:0] my;
		logic [MAG_W-1:0] mz;
		logic             deg;
	} vec_info_t;

	typedef struct packed {
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		vec_info_t         v;
	} sqrt_stage_t;

	typedef struct packed {
		logic [2:0][DREM_W-1:0] r;
		logic [2:0][QUO_W-1:0]  q;
		logic [2:0][QUO_W-1:0]  low;
		logic [ROOT_W-1:0]      m;
		logic [2:0]             neg;
		logic                   deg;
	} div_stage_t;

endpackage

/* rtl/core/triangle_normal_and_area.sv */
// ----------------------------------------------------------------------------
// triangle_normal_and_area
// unit normal (signed Q1.14) and area (unsigned Q.12) of one triangle per beat
// ----------------------------------------------------------------------------
// input channel tri_valid/tri_ready carries vertices a, b, c in signed Q4.12
// output channel res_valid/res_ready carries normal_x/y/z, area, degenerate
// from input beat to output beat the pipeline runs through 6 setup stages (edges,
// products, cross, magnitude, squares, sum), 34 square root stages with one
// root bit each, one divider setup stage, 15 divide stages with one quotient
// bit each for all three components, and the output register
// throughput is one triangle per cycle while res_ready is high
// the whole pipeline moves as one: when the output register holds a beat and
// res_ready is low, every stage holds and tri_ready goes low; no beat is lost
// a zero cross product gives degenerate = 1 with zero normal and zero area
// reset clears all valid bits; the pipeline comes up empty
// ----------------------------------------------------------------------------
module triangle_normal_and_area (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tri_valid,
	output logic               tri_ready,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] ay,
	input  logic signed [15:0] az,
	input  logic signed [15:0] bx,
	input  logic signed [15:0] by,
	input  logic signed [15:0] bz,
	input  logic signed [15:0] cx,
	input  logic signed [15:0] cy,
	input  logic signed [15:0] cz,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [20:0]        area,
	output logic               degenerate
);

	localparam int NSTG = 6 + tna_pkg::ROOT_W + 1 + tna_pkg::QUO_W + 1;

	logic            adv;
	logic [NSTG-1:0] vld_q;

	assign adv       = ~res_valid | res_ready;
	assign tri_ready = adv;
	assign res_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], tri_valid};
		end
	end

	// stage 1: edges
	logic signed [tna_pkg::EDGE_W-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			e1x_s1 <= tna_pkg::EDGE_W'(bx) - tna_pkg::EDGE_W'(ax);
			e1y_s1 <= tna_pkg::EDGE_W'(by) - tna_pkg::EDGE_W'(ay);
			e1z_s1 <= tna_pkg::EDGE_W'(bz) - tna_pkg::EDGE_W'(az);
			e2x_s1 <= tna_pkg::EDGE_W'(cx) - tna_pkg::EDGE_W'(ax);
			e2y_s1 <= tna_pkg::EDGE_W'(cy) - tna_pkg::EDGE_W'(ay);
			e2z_s1 <= tna_pkg::EDGE_W'(cz) - tna_pkg::EDGE_W'(az);
		end
	end

	// stage 2: six partial products
	logic signed [tna_pkg::PROD_W-1:0] p_s2 [6];
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= tna_pkg::PROD_W'(e1y_s1) * tna_pkg::PROD_W'(e2z_s1);
			p_s2[1] <= tna_pkg::PROD_W'(e1z_s1) * tna_pkg::PROD_W'(e2y_s1);
			p_s2[2] <= tna_pkg::PROD_W'(e1z_s1) * tna_pkg::PROD_W'(e2x_s1);
			p_s2[3] <= tna_pkg::PROD_W'(e1x_s1) * tna_pkg::PROD_W'(e2z_s1);
			p_s2[4] <= tna_pkg::PROD_W'(e1x_s1) * tna_pkg::PROD_W'(e2y_s1);
			p_s2[5] <= tna_pkg::PROD_W'(e1y_s1) * tna_pkg::PROD_W'(e2x_s1);
		end
	end

	// stage 3: cross product
	logic signed [tna_pkg::CROSS_W-1:0] xx_s3, xy_s3, xz_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s3 <= tna_pkg::CROSS_W'(p_s2[0]) - tna_pkg::CROSS_W'(p_s2[1]);
			xy_s3 <= tna_pkg::CROSS_W'(p_s2[2]) - tna_pkg::CROSS_W'(p_s2[3]);
			xz_s3 <= tna_pkg::CROSS_W'(p_s2[4]) - tna_pkg::CROSS_W'(p_s2[5]);
		end
	end

	// stage 4: sign and magnitude
	tna_pkg::vec_info_t v_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s4.neg <= {xz_s3[tna_pkg::CROSS_W-1], xy_s3[tna_pkg::CROSS_W-1],
				xx_s3[tna_pkg::CROSS_W-1]};
			v_s4.mx  <= tna_pkg::MAG_W'(xx_s3[tna_pkg::CROSS_W-1] ? -xx_s3 : xx_s3);
			v_s4.my  <= tna_pkg::MAG_W'(xy_s3[tna_pkg::CROSS_W-1] ? -xy_s3 : xy_s3);
			v_s4.mz  <= tna_pkg::MAG_W'(xz_s3[tna_pkg::CROSS_W-1] ? -xz_s3 : xz_s3);
			v_s4.deg <= (xx_s3 == '0) && (xy_s3 == '0) && (xz_s3 == '0);
		end
	end

	// stage 5: squares
	logic [tna_pkg::SQ_W-1:0] sqx_s5, sqy_s5, sqz_s5;
	tna_pkg::vec_info_t       v_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s5 <= tna_pkg::SQ_W'(v_s4.mx) * tna_pkg::SQ_W'(v_s4.mx);
			sqy_s5 <= tna_pkg::SQ_W'(v_s4.my) * tna_pkg::SQ_W'(v_s4.my);
			sqz_s5 <= tna_pkg::SQ_W'(v_s4.mz) * tna_pkg::SQ_W'(v_s4.mz);
			v_s5   <= v_s4;
		end
	end

	// stage 6: squared length
	logic [tna_pkg::SUM_W-1:0] sum_s6;
	tna_pkg::vec_info_t        v_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s6 <= tna_pkg::SUM_W'(sqx_s5) + tna_pkg::SUM_W'(sqy_s5)
				+ tna_pkg::SUM_W'(sqz_s5);
			v_s6   <= v_s5;
		end
	end

	// square root, one result bit per stage
	function automatic tna_pkg::sqrt_stage_t sqrt_step(input tna_pkg::sqrt_stage_t a);
		tna_pkg::sqrt_stage_t     o;
		logic [tna_pkg::REM_W-1:0] cur;
		logic [tna_pkg::REM_W-1:0] trial;
		o     = a;
		cur   = {a.rem[tna_pkg::REM_W-3:0], a.rad[tna_pkg::SUM_W-1 -: 2]};
		trial = tna_pkg::REM_W'({a.root, 2'b01});
		o.rad = {a.rad[tna_pkg::SUM_W-3:0], 2'b00};
		if (cur >= trial) begin
			o.rem  = cur - trial;
			o.root = {a.root[tna_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = cur;
			o.root = {a.root[tna_pkg::ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	tna_pkg::sqrt_stage_t sqrt_in [tna_pkg::ROOT_W];
	tna_pkg::sqrt_stage_t sqrt_s  [tna_pkg::ROOT_W];

	always_comb begin
		sqrt_in[0].rad  = sum_s6;
		sqrt_in[0].rem  = '0;
		sqrt_in[0].root = '0;
		sqrt_in[0].v    = v_s6;
	end

	for (genvar k = 0; k < tna_pkg::ROOT_W; k++) begin : g_sqrt
		if (k > 0) begin : g_link
			assign sqrt_in[k] = sqrt_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_s[k] <= sqrt_step(sqrt_in[k]);
			end
		end
	end

	// divider setup: dividend is |x| * 2^15 + m, divisor 2m
	tna_pkg::sqrt_stage_t     sq_last;
	logic [tna_pkg::DSUM_W-1:0] dsum [3];
	tna_pkg::div_stage_t      prep_s;

	assign sq_last = sqrt_s[tna_pkg::ROOT_W-1];

	always_comb begin
		dsum[0] = tna_pkg::DSUM_W'({sq_last.v.mx, 15'd0}) + tna_pkg::DSUM_W'(sq_last.root);
		dsum[1] = tna_pkg::DSUM_W'({sq_last.v.my, 15'd0}) + tna_pkg::DSUM_W'(sq_last.root);
		dsum[2] = tna_pkg::DSUM_W'({sq_last.v.mz, 15'd0}) + tna_pkg::DSUM_W'(sq_last.root);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				prep_s.r[c]   <= tna_pkg::DREM_W'(dsum[c][tna_pkg::DSUM_W-1:tna_pkg::QUO_W]);
				prep_s.low[c] <= dsum[c][tna_pkg::QUO_W-1:0];
				prep_s.q[c]   <= '0;
			end
			prep_s.m   <= sq_last.root;
			prep_s.neg <= sq_last.v.neg;
			prep_s.deg <= sq_last.v.deg;
		end
	end

	// restoring division, one quotient bit per stage for all three components
	function automatic tna_pkg::div_stage_t div_step(input tna_pkg::div_stage_t a);
		tna_pkg::div_stage_t       o;
		logic [tna_pkg::DREM_W-1:0] cur;
		logic [tna_pkg::DREM_W-1:0] d2;
		o  = a;
		d2 = tna_pkg::DREM_W'({a.m, 1'b0});
		for (int c = 0; c < 3; c++) begin
			cur      = {a.r[c][tna_pkg::DREM_W-2:0], a.low[c][tna_pkg::QUO_W-1]};
			o.low[c] = {a.low[c][tna_pkg::QUO_W-2:0], 1'b0};
			if (cur >= d2) begin
				o.r[c] = cur - d2;
				o.q[c] = {a.q[c][tna_pkg::QUO_W-2:0], 1'b1};
			end else begin
				o.r[c] = cur;
				o.q[c] = {a.q[c][tna_pkg::QUO_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	tna_pkg::div_stage_t div_in [tna_pkg::QUO_W];
	tna_pkg::div_stage_t div_s  [tna_pkg::QUO_W];

	assign div_in[0] = prep_s;

	for (genvar k = 0; k < tna_pkg::QUO_W; k++) begin : g_div
		if (k > 0) begin : g_link
			assign div_in[k] = div_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= div_step(div_in[k]);
			end
		end
	end

	// output stage: clamp, sign, area
	tna_pkg::div_stage_t         dl;
	logic [tna_pkg::QUO_W-1:0]   qc [3];
	logic signed [tna_pkg::NORM_W-1:0] nv [3];
	logic [tna_pkg::ROOT_W:0]    asum;
	logic [tna_pkg::AREA_RW-1:0] araw;
	logic [tna_pkg::AREA_W-1:0]  asat;

	assign dl = div_s[tna_pkg::QUO_W-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qc[c] = (dl.q[c] > tna_pkg::NORMAL_ONE) ? tna_pkg::NORMAL_ONE : dl.q[c];
			nv[c] = dl.neg[c] ? -tna_pkg::NORM_W'(qc[c]) : tna_pkg::NORM_W'(qc[c]);
		end
		asum = (tna_pkg::ROOT_W+1)'(dl.m) + (tna_pkg::ROOT_W+1)'(4096);
		araw = asum[tna_pkg::ROOT_W:13];
		asat = (araw > tna_pkg::AREA_RW'(tna_pkg::AREA_MAX)) ? tna_pkg::AREA_MAX
			: araw[tna_pkg::AREA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			normal_x   <= dl.deg ? '0 : nv[0];
			normal_y   <= dl.deg ? '0 : nv[1];
			normal_z   <= dl.deg ? '0 : nv[2];
			area       <= dl.deg ? '0 : asat;
			degenerate <= dl.deg;
		end
	end

endmodule

/* rtl/core/tna_checker.sv */
// ----------------------------------------------------------------------------
// tna_checker
// port level checks on the triangle normal and area block
// ----------------------------------------------------------------------------
`include "triangle_normal_and_area_defines.svh"

module tna_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               tri_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic [20:0]        area,
	input logic               degenerate
);

	logic zero_beat;
	logic x_ok, y_ok, z_ok;

	assign zero_beat = normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0
		&& area == 21'd0;
	assign x_ok = normal_x <= 16'sd16384 && normal_x >= -16'sd16384;
	assign y_ok = normal_y <= 16'sd16384 && normal_y >= -16'sd16384;
	assign z_ok = normal_z <= 16'sd16384 && normal_z >= -16'sd16384;

	`TNA_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !res_valid, "result beat shown during reset")
	`TNA_ASSERT(a_hold, res_valid && !res_ready |=> res_valid, "result beat dropped while stalled")
	`TNA_ASSERT(a_flow, res_ready |-> tri_ready, "input stalled while receiver takes beats")
	`TNA_ASSERT(a_degen_zero, res_valid && degenerate |-> zero_beat, "degenerate beat nonzero")
	`TNA_ASSERT(a_unit_range, res_valid |-> x_ok && y_ok && z_ok, "normal component out of range")

endmodule

bind triangle_normal_and_area tna_checker u_tna_checker (.*);

/* tb/triangle_normal_and_area_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_normal_and_area_tb
// drives triangles through the normal and area pipeline under random bursts
// and output stalls, predicts normal and area exactly in wide integer math
// and compares every result beat in order
// ----------------------------------------------------------------------------

class tri_scoreboard;
	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic [20:0]        area;
		logic               deg;
	} shape_t;

	shape_t      pending[$];
	int unsigned mismatches;
	int unsigned checked;
	int unsigned deg_seen;

	function new();
		mismatches = 0;
		checked = 0;
		deg_seen = 0;
	endfunction

	// floor square root of a 68-bit sum, one bit at a time
	static function logic [34:0] isqrt(logic [67:0] s);
		logic [34:0]  r;
		logic [34:0]  t;
		logic [69:0]  sq;
		r = '0;
		for (int b = 34; b >= 0; b--) begin
			t = r | (35'd1 << b);
			sq = 70'(t) * 70'(t);
			if (sq <= 70'(s))
				r = t;
		end
		return r;
	endfunction

	static function logic signed [15:0] unit_comp(logic signed [35:0] x, logic [34:0] m);
		logic [35:0]  mag;
		logic [51:0]  num;
		logic [52:0]  q;
		logic [15:0]  v;
		mag = x < 0 ? 36'(-x) : 36'(x);
		num = 52'(mag) << 14;
		q = (53'(num) * 2 + 53'(m)) / (53'(m) * 2);
		if (q > 53'd16384)
			q = 53'd16384;
		v = 16'(q);
		if (x < 0)
			v = -v;
		return v;
	endfunction

	function void note_triangle(logic signed [15:0] v[9]);
		logic signed [35:0] e1x, e1y, e1z, e2x, e2y, e2z, xx, xy, xz;
		logic [67:0]        s;
		logic [34:0]        m;
		logic [35:0]        ar;
		shape_t             e;
		e1x = v[3] - v[0]; e1y = v[4] - v[1]; e1z = v[5] - v[2];
		e2x = v[6] - v[0]; e2y = v[7] - v[1]; e2z = v[8] - v[2];
		xx = e1y * e2z - e1z * e2y;
		xy = e1z * e2x - e1x * e2z;
		xz = e1x * e2y - e1y * e2x;
		s = 68'(xx) * 68'(xx) + 68'(xy) * 68'(xy) + 68'(xz) * 68'(xz);
		if (s == 0) begin
			e = '{0, 0, 0, 0, 1'b1};
		end else begin
			m = isqrt(s);
			ar = (36'(m) + 36'd4096) >> 13;
			if (ar > 36'd2097151)
				ar = 36'd2097151;
			e.nx = unit_comp(xx, m);
			e.ny = unit_comp(xy, m);
			e.nz = unit_comp(xz, m);
			e.area = 21'(ar);
			e.deg = 1'b0;
		end
		pending.push_back(e);
	endfunction

	function void check_result(logic signed [15:0] nx, ny, nz, logic [20:0] area,
		logic deg);
		shape_t e;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: nx=%0d ny=%0d nz=%0d area=%0d deg=%0b",
					nx, ny, nz, area, deg);
			return;
		end
		e = pending.pop_front();
		if (deg)
			deg_seen++;
		if (nx !== e.nx || ny !== e.ny || nz !== e.nz || area !== e.area || deg !== e.deg) begin
			mismatches++;
			if (mismatches <= 10)
				$display("beat %0d: exp (%0d,%0d,%0d) a=%0d d=%0b got (%0d,%0d,%0d) a=%0d d=%0b",
					checked, e.nx, e.ny, e.nz, e.area, e.deg, nx, ny, nz, area, deg);
		end
	endfunction
endclass

module triangle_normal_and_area_tb;

	localparam int LATENCY = 57;

	logic               clk;
	logic               arst_n;
	logic               tri_valid;
	logic               tri_ready;
	logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic               res_valid;
	logic               res_ready;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [20:0]        area;
	logic               degenerate;

	tri_scoreboard sb;
	bit            long_hold;
	int unsigned   sent;

	triangle_normal_and_area u_dut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.cx(cx), .cy(cy), .cz(cz),
		.res_valid(res_valid), .res_ready(res_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.area(area), .degenerate(degenerate)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// one beat: holds valid and payload until accepted, then leaves valid high
	task automatic send_triangle(logic signed [15:0] v[9]);
		tri_valid <= 1'b1;
		{ax, ay, az, bx, by, bz, cx, cy, cz} <= {v[0], v[1], v[2], v[3], v[4], v[5],
			v[6], v[7], v[8]};
		sb.note_triangle(v);
		@(posedge clk);
		while (!tri_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic idle_input(int n);
		tri_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_triangle();
		logic signed [15:0] v[9];
		int                 kind;
		kind = $urandom_range(0, 9);
		foreach (v[i])
			v[i] = rand_coord();
		if (kind == 0) begin
			// collinear: c = a + k*(b-a) with small k
			for (int i = 0; i < 3; i++)
				v[6 + i] = v[i] + (v[3 + i] - v[i]) * $signed(16'($urandom_range(0, 2)));
		end else if (kind == 1) begin
			// two vertices equal
			for (int i = 0; i < 3; i++)
				v[3 + i] = v[i];
		end else if (kind == 2) begin
			// small triangle, exercises rounding near one in the normal
			for (int i = 3; i < 9; i++)
				v[i] = v[i % 3] + 16'($urandom_range(0, 6)) - 16'sd3;
		end
		send_triangle(v);
	endtask

	// receiver: random stall pattern, plus one long hold-off on request
	initial begin
		res_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res_ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: res_ready <= 1'b0;
				1: res_ready <= ($urandom_range(0, 1) == 1);
				default: res_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(normal_x, normal_y, normal_z, area, degenerate);
	end

	initial begin
		#4000000;
		$display("timeout");
		$display("triangle_normal_and_area_tb: errors");
		$finish;
	end

	initial begin
		logic signed [15:0] v[9];
		int                 burst;
		sb = new();
		sent = 0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		tri_valid = 1'b0;
		{ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: degenerate, axis-aligned, extremes, max area
		v = '{default: 16'sd0};
		send_triangle(v);
		v = '{0, 0, 0, 16'sd4096, 0, 0, 0, 16'sd4096, 0};
		send_triangle(v);
		v = '{0, 0, 0, 0, 16'sd4096, 0, 0, 0, 16'sd4096};
		send_triangle(v);
		v = '{0, 0, 0, 0, 0, 16'sd4096, 16'sd4096, 0, 0};
		send_triangle(v);
		v = '{0, 0, 0, 0, 16'sd4096, 0, 16'sd4096, 0, 0};
		send_triangle(v);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh8000};
		send_triangle(v);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh7fff};
		send_triangle(v);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh7fff};
		send_triangle(v);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000};
		send_triangle(v);
		v = '{-16'sd1, -16'sd1, -16'sd1, 0, 0, 0, 16'sd1, 16'sd1, 16'sd1};
		send_triangle(v);
		v = '{0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1, 0};
		send_triangle(v);
		v = '{0, 0, 0, 16'sd1, 16'sd1, 0, 0, 16'sd1, 16'sd1};
		send_triangle(v);
		v = '{16'sd5, -16'sd7, 16'sd3, -16'sd2, 16'sd9, 16'sd1, 16'sd4, 16'sd4, -16'sd6};
		send_triangle(v);
		v = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
			16'sh1234, 16'shedcb, 16'sh0f0f};
		send_triangle(v);

		// drain fully before the random part
		idle_input(0);
		while (sb.pending.size() != 0)
			@(posedge clk);

		for (int i = 0; i < 1700; ) begin
			burst = $urandom_range(1, 40);
			// bursts are at most 40 long, so this window is always hit
			if (i >= 300 && i < 340)
				long_hold = 1'b1;
			for (int k = 0; k < burst && i < 1700; k++, i++)
				random_triangle();
			if (i > 900 && i < 950) begin
				// let the pipe empty completely at least once in the middle
				idle_input(0);
				while (sb.pending.size() != 0)
					@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				idle_input($urandom_range(1, 12));
			end
		end
		tri_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d triangles, checked %0d result beats, %0d degenerate",
			sent, sb.checked, sb.deg_seen);
		$display("with random bursts, output stalls and one long output hold-off");
		if (sb.mismatches == 0)
			$display("triangle_normal_and_area_tb: clean");
		else
			$display("triangle_normal_and_area_tb: errors");
		$finish;
	end
endmodule
